// ===== rtl/rgb2yuv_pkg.sv =====
// shared word types for the rgb block to yuv 4:2:0 converter
package rgb2yuv_pkg;

    localparam int SAMPLE_W = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // one 2x2 block of rgb pixels
    typedef struct packed {
        sample_t red_top_left;
        sample_t green_top_left;
        sample_t blue_top_left;
        sample_t red_top_right;
        sample_t green_top_right;
        sample_t blue_top_right;
        sample_t red_bottom_left;
        sample_t green_bottom_left;
        sample_t blue_bottom_left;
        sample_t red_bottom_right;
        sample_t green_bottom_right;
        sample_t blue_bottom_right;
    } rgb_block_t;

    // four luma samples and the shared chroma pair
    typedef struct packed {
        sample_t luma_top_left;
        sample_t luma_top_right;
        sample_t luma_bottom_left;
        sample_t luma_bottom_right;
        sample_t chroma_blue;
        sample_t chroma_red;
    } yuv_block_t;

endpackage

// ===== rtl/rgb2yuv_rgb_if.sv =====
// valid/ready channel carrying one rgb block word
interface rgb2yuv_rgb_if
    import rgb2yuv_pkg::*;
();
    logic       valid;
    logic       ready;
    rgb_block_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rgb2yuv_yuv_if.sv =====
// valid/ready channel carrying one yuv 4:2:0 block word
interface rgb2yuv_yuv_if
    import rgb2yuv_pkg::*;
();
    logic       valid;
    logic       ready;
    yuv_block_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rgb_block_to_yuv420.sv =====
// 2x2 rgb block to yuv 4:2:0 converter, four-stage pipeline
//
//  channel | direction | word
//  --------+-----------+---------------------------------------------
//  rgb     | in        | rgb_block_t: twelve 8-bit colour samples
//  yuv     | out       | yuv_block_t: four luma, chroma blue and red
//
// one block per cycle sustained while yuv.ready stays high
// stages: luma sums, luma clamp and chroma difference sums, chroma
// coefficient multiply, offset add and clamp into the output register
// each stage moves on when empty or when the stage after it moves, so
// bubbles close up under a stall; rst_n clears only the valid bits
module rgb_block_to_yuv420
    import rgb2yuv_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)(
    input  logic           clk,
    input  logic           rst_n,
    rgb2yuv_rgb_if.sink    rgb,
    rgb2yuv_yuv_if.source  yuv
);

    localparam int F  = FRACTION_BITS;
    localparam int YW = F + 9;          // unsigned luma, F fractional bits
    localparam int DW = F + 10;         // signed per-pixel colour minus luma
    localparam int SW = F + 12;         // signed sum over the block
    localparam int PW = 2 * F + 13;     // signed chroma, 2F fractional bits
    localparam int CF = 2 * F + 2;      // fractional bits of the block average

    // rounded coefficients
    localparam longint COEF_R = ((longint'(299) << F) + 64'sd500) / 64'sd1000;
    localparam longint COEF_G = ((longint'(587) << F) + 64'sd500) / 64'sd1000;
    localparam longint COEF_B = ((longint'(114) << F) + 64'sd500) / 64'sd1000;
    localparam longint COEF_C = ((longint'(492) << F) + 64'sd500) / 64'sd1000;

    localparam logic [YW-1:0]        LUMA_R   = YW'(COEF_R);
    localparam logic [YW-1:0]        LUMA_G   = YW'(COEF_G);
    localparam logic [YW-1:0]        LUMA_B   = YW'(COEF_B);
    localparam logic signed [PW-1:0] CHROMA_C = PW'(COEF_C);
    localparam logic signed [PW-1:0] OFFSET   = PW'(128) <<< CF;

    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = '1;

    // stage enables
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign en4 = !v4_reg || yuv.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign rgb.ready = en1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= rgb.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // unpack the block by pixel
    sample_t red [4];
    sample_t green [4];
    sample_t blue [4];

    always_comb
    begin
        red[0]   = rgb.data.red_top_left;
        green[0] = rgb.data.green_top_left;
        blue[0]  = rgb.data.blue_top_left;
        red[1]   = rgb.data.red_top_right;
        green[1] = rgb.data.green_top_right;
        blue[1]  = rgb.data.blue_top_right;
        red[2]   = rgb.data.red_bottom_left;
        green[2] = rgb.data.green_bottom_left;
        blue[2]  = rgb.data.blue_bottom_left;
        red[3]   = rgb.data.red_bottom_right;
        green[3] = rgb.data.green_bottom_right;
        blue[3]  = rgb.data.blue_bottom_right;
    end

    // stage 1: per-pixel luma
    logic [YW-1:0] y_next [4];
    logic [YW-1:0] y_reg [4];
    sample_t       r1_reg [4];
    sample_t       b1_reg [4];

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            y_next[p] = LUMA_R * YW'(red[p]) + LUMA_G * YW'(green[p])
                      + LUMA_B * YW'(blue[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int p = 0; p < 4; p++)
            begin
                y_reg[p]  <= y_next[p];
                r1_reg[p] <= red[p];
                b1_reg[p] <= blue[p];
            end
        end
    end

    // stage 2: clamp luma, sum colour minus luma over the block
    sample_t                luma_next [4];
    sample_t                luma2_reg [4];
    logic signed [DW-1:0]   du [4];
    logic signed [DW-1:0]   dv [4];
    logic signed [SW-1:0]   du_sum_next, dv_sum_next;
    logic signed [SW-1:0]   du_sum_reg, dv_sum_reg;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            luma_next[p] = y_reg[p][F+8] ? SAMPLE_MAX : y_reg[p][F+7:F];
            du[p] = $signed({2'b00, b1_reg[p], F'(0)}) - $signed({1'b0, y_reg[p]});
            dv[p] = $signed({2'b00, r1_reg[p], F'(0)}) - $signed({1'b0, y_reg[p]});
        end
        du_sum_next = (SW'(du[0]) + SW'(du[1])) + (SW'(du[2]) + SW'(du[3]));
        dv_sum_next = (SW'(dv[0]) + SW'(dv[1])) + (SW'(dv[2]) + SW'(dv[3]));
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            luma2_reg  <= luma_next;
            du_sum_reg <= du_sum_next;
            dv_sum_reg <= dv_sum_next;
        end
    end

    // stage 3: chroma coefficient multiply
    sample_t              luma3_reg [4];
    logic signed [PW-1:0] u_prod_reg, v_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            luma3_reg  <= luma2_reg;
            u_prod_reg <= CHROMA_C * PW'(du_sum_reg);
            v_prod_reg <= CHROMA_C * PW'(dv_sum_reg);
        end
    end

    // stage 4: add offset, floor and clamp into the output word
    logic signed [PW-1:0] u_full, v_full;
    sample_t              u_byte, v_byte;
    yuv_block_t           out_next, out_reg;

    function automatic sample_t clamp_chroma(input logic signed [PW-1:0] val);
        sample_t res;
        if (val[PW-1])
            res = '0;
        else if (|val[PW-2:CF+8])
            res = SAMPLE_MAX;
        else
            res = val[CF+7:CF];
        return res;
    endfunction

    always_comb
    begin
        u_full = u_prod_reg + OFFSET;
        v_full = v_prod_reg + OFFSET;
        u_byte = clamp_chroma(u_full);
        v_byte = clamp_chroma(v_full);
        out_next.luma_top_left     = luma3_reg[0];
        out_next.luma_top_right    = luma3_reg[1];
        out_next.luma_bottom_left  = luma3_reg[2];
        out_next.luma_bottom_right = luma3_reg[3];
        out_next.chroma_blue       = u_byte;
        out_next.chroma_red        = v_byte;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
            out_reg <= out_next;
    end

    assign yuv.valid = v4_reg;
    assign yuv.data  = out_reg;

`ifndef ASSERT_OFF
    // an accepted word lands in stage 1
    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        rgb.valid && rgb.ready |=> v1_reg)
        else $error("accepted word not held in stage 1");

    // input only stalls when every stage is full
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rgb.ready |-> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("input stalled with a free stage");

    // a stage 3 word blocked downstream stays put
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !en4 |=> v3_reg)
        else $error("stage 3 word lost under stall");

    // a stage 2 word that moves reaches stage 3
    a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && en3 |=> v3_reg)
        else $error("stage 2 word dropped");
`endif

endmodule

// ===== verif/rgb_block_to_yuv420_tb.sv =====
// testbench for the 2x2 rgb block to yuv 4:2:0 converter: predicted words checked under stalls
module rgb_block_to_yuv420_tb
    import rgb2yuv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC        = 16;
    localparam int     CHROMA_FRAC = 2 * FRAC + 2;
    localparam longint K_RED       = ((longint'(299) << FRAC) + 500) / 1000;
    localparam longint K_GREEN     = ((longint'(587) << FRAC) + 500) / 1000;
    localparam longint K_BLUE      = ((longint'(114) << FRAC) + 500) / 1000;
    localparam longint K_CHROMA    = ((longint'(492) << FRAC) + 500) / 1000;
    localparam longint UV_OFFSET   = longint'(128) << CHROMA_FRAC;
    localparam sample_t SAMPLE_MAX = '1;
    localparam int     IDLE_LIMIT  = 2000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_CYCLES = 8;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
    } pixel_t;

    logic clk;
    logic rst_n;

    rgb2yuv_rgb_if rgb_ch ();
    rgb2yuv_yuv_if yuv_ch ();

    rgb_block_to_yuv420 #(
        .FRACTION_BITS(FRAC)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb_ch),
        .yuv   (yuv_ch)
    );

    yuv_block_t pending_yuv[$];
    int         mismatch_count;
    int         src_gap_pct;
    int         sink_stall_pct;
    bit         hold_request;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor a fixed value to a sample, saturating at both ends
    function automatic sample_t clamp_floor(longint v, int frac);
        if (v < 0)
            return '0;
        if (v >= (longint'(256) << frac))
            return SAMPLE_MAX;
        return sample_t'(v >>> frac);
    endfunction

    // yuv 4:2:0 word that one rgb block should turn into
    function automatic yuv_block_t predict_yuv(rgb_block_t blk);
        pixel_t     quad [4];
        longint     luma [4];
        longint     r, g, b;
        longint     sum_u, sum_v;
        yuv_block_t res;
        quad[0] = {blk.red_top_left, blk.green_top_left, blk.blue_top_left};
        quad[1] = {blk.red_top_right, blk.green_top_right, blk.blue_top_right};
        quad[2] = {blk.red_bottom_left, blk.green_bottom_left, blk.blue_bottom_left};
        quad[3] = {blk.red_bottom_right, blk.green_bottom_right, blk.blue_bottom_right};
        sum_u = 0;
        sum_v = 0;
        for (int p = 0; p < 4; p++)
        begin
            r = longint'(quad[p].red);
            g = longint'(quad[p].green);
            b = longint'(quad[p].blue);
            luma[p] = K_RED * r + K_GREEN * g + K_BLUE * b;
            // chroma differences use the unclamped luma
            sum_u += K_CHROMA * ((b << FRAC) - luma[p]);
            sum_v += K_CHROMA * ((r << FRAC) - luma[p]);
        end
        res.luma_top_left     = clamp_floor(luma[0], FRAC);
        res.luma_top_right    = clamp_floor(luma[1], FRAC);
        res.luma_bottom_left  = clamp_floor(luma[2], FRAC);
        res.luma_bottom_right = clamp_floor(luma[3], FRAC);
        // the sum read with two more fraction bits is the block average
        res.chroma_blue       = clamp_floor(sum_u + UV_OFFSET, CHROMA_FRAC);
        res.chroma_red        = clamp_floor(sum_v + UV_OFFSET, CHROMA_FRAC);
        return res;
    endfunction

    task automatic report_mismatch(string what, sample_t got, sample_t want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic sample_t rand_sample(bit palette);
        sample_t picks [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if (palette)
            return picks[$urandom_range(5)];
        return sample_t'($urandom_range(255));
    endfunction

    function automatic rgb_block_t rand_block(bit palette);
        rgb_block_t blk;
        for (int i = 0; i < 12; i++)
            blk[i*SAMPLE_W +: SAMPLE_W] = rand_sample(palette);
        return blk;
    endfunction

    function automatic rgb_block_t uniform_block(sample_t r, sample_t g, sample_t b);
        pixel_t px;
        px = {r, g, b};
        return rgb_block_t'({px, px, px, px});
    endfunction

    // offer one block word, wait for acceptance, then record its prediction
    task automatic send_block(rgb_block_t blk);
        int gap;
        gap = ($urandom_range(99) < src_gap_pct) ? idle_len() : 0;
        if (gap > 0)
        begin
            rgb_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rgb_ch.valid <= 1'b1;
        rgb_ch.data  <= blk;
        do
            @(posedge clk);
        while (!rgb_ch.ready);
        pending_yuv.push_back(predict_yuv(blk));
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        yuv_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                yuv_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                yuv_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(99) < sink_stall_pct)
            begin
                yuv_ch.ready <= 1'b0;
                stall_left = idle_len() - 1;
            end
            else
            begin
                yuv_ch.ready <= 1'b1;
            end
        end
    end

    // compare each accepted yuv word with the oldest prediction
    always @(posedge clk)
    begin
        yuv_block_t want;
        yuv_block_t got;
        if (rst_n && yuv_ch.valid && yuv_ch.ready)
        begin
            got = yuv_ch.data;
            if (pending_yuv.size() == 0)
            begin
                $display("[%0t] unexpected yuv word %h", $realtime, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_yuv.pop_front();
                if (got.luma_top_left !== want.luma_top_left)
                    report_mismatch("luma_top_left", got.luma_top_left, want.luma_top_left);
                if (got.luma_top_right !== want.luma_top_right)
                    report_mismatch("luma_top_right", got.luma_top_right, want.luma_top_right);
                if (got.luma_bottom_left !== want.luma_bottom_left)
                    report_mismatch("luma_bottom_left", got.luma_bottom_left,
                                    want.luma_bottom_left);
                if (got.luma_bottom_right !== want.luma_bottom_right)
                    report_mismatch("luma_bottom_right", got.luma_bottom_right,
                                    want.luma_bottom_right);
                if (got.chroma_blue !== want.chroma_blue)
                    report_mismatch("chroma_blue", got.chroma_blue, want.chroma_blue);
                if (got.chroma_red !== want.chroma_red)
                    report_mismatch("chroma_red", got.chroma_red, want.chroma_red);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((rgb_ch.valid && rgb_ch.ready) || (yuv_ch.valid && yuv_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rgb_block_to_yuv420_tb NOT OK");
            $finish;
        end
    end

    // black, white, primaries, secondaries, greys, bit patterns and mixed blocks
    task automatic test_corner_blocks();
        src_gap_pct    = 30;
        sink_stall_pct = 20;
        send_block(uniform_block(8'd0, 8'd0, 8'd0));
        send_block(uniform_block(8'd255, 8'd255, 8'd255));
        send_block(uniform_block(8'd255, 8'd0, 8'd0));
        send_block(uniform_block(8'd0, 8'd255, 8'd0));
        send_block(uniform_block(8'd0, 8'd0, 8'd255));
        // lowest chroma blue and lowest chroma red
        send_block(uniform_block(8'd255, 8'd255, 8'd0));
        send_block(uniform_block(8'd0, 8'd255, 8'd255));
        send_block(uniform_block(8'd255, 8'd0, 8'd255));
        send_block(uniform_block(8'd1, 8'd1, 8'd1));
        send_block(uniform_block(8'd254, 8'd254, 8'd254));
        send_block(uniform_block(8'd128, 8'd128, 8'd128));
        send_block(uniform_block(8'h55, 8'hAA, 8'h55));
        send_block(uniform_block(8'hAA, 8'h55, 8'hAA));
        // pixels differing inside one block
        send_block(rgb_block_t'({24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h0000FF}));
        send_block(rgb_block_t'({24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h000000}));
        send_block(rgb_block_t'({24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF}));
    endtask

    // back to back words with neither side idling
    task automatic test_streaming_no_gaps();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        repeat (300) send_block(rand_block(1'b0));
    endtask

    // random idling on both sides
    task automatic test_random_idling();
        src_gap_pct    = 35;
        sink_stall_pct = 30;
        repeat (650) send_block(rand_block(1'b0));
    endtask

    // samples at the range ends and around the midpoint, where clamping would show
    task automatic test_edge_samples();
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        repeat (200) send_block(rand_block(1'b1));
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_output_hold_off();
        src_gap_pct    = 0;
        sink_stall_pct = 10;
        hold_request   = 1'b1;
        repeat (60) send_block(rand_block(1'b0));
    endtask

    initial
    begin
        mismatch_count  = 0;
        hold_request    = 1'b0;
        src_gap_pct     = 0;
        sink_stall_pct  = 0;
        rst_n          <= 1'b0;
        rgb_ch.valid   <= 1'b0;
        rgb_ch.data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_blocks();
        test_streaming_no_gaps();
        test_output_hold_off();
        test_random_idling();
        test_edge_samples();

        rgb_ch.valid <= 1'b0;
        while (pending_yuv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("rgb_block_to_yuv420_tb OK");
        else
            $display("rgb_block_to_yuv420_tb NOT OK");
        $finish;
    end

endmodule
